[sv/lowest_free_id_linked_table_defines.svh]
// Assertion macros shared by the lowest-free-id linked table RTL.
`ifndef LOWEST_FREE_ID_LINKED_TABLE_DEFINES_SVH
`define LOWEST_FREE_ID_LINKED_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LFIT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/lfit_pkg.sv]
// Constants and types for the lowest-free-id linked table.
`default_nettype none

package lfit_pkg;

   // Table geometry. The id field is 8 bits, so the table spans all 256 ids.
   localparam int ID_W    = 8;
   localparam int MAX_IDS = 1 << ID_W;
   localparam int DATA_W  = 32;
   localparam int CMD_W   = 2;
   localparam int STS_W   = 2;

   // Stream word widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((ID_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ID_W + DATA_W + 7) / 8) * 8;

   // The free-id search splits the used marks into groups.
   localparam int BIT_IDX_W = ID_W / 2;
   localparam int GRP_IDX_W = ID_W - BIT_IDX_W;
   localparam int GRP_W     = 1 << BIT_IDX_W;
   localparam int GRP_N     = 1 << GRP_IDX_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_NEXT   = 2'd3
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK     = 2'd0,
      STS_FULL   = 2'd1,
      STS_UNUSED = 2'd2
   } status_type;

   // One link memory word: back link and forward link of an entry.
   typedef struct packed {
      logic [ID_W-1:0] prv;
      logic [ID_W-1:0] nxt;
   } link_type;

endpackage

`default_nettype wire

[sv/lowest_free_id_linked_table.sv]
// Lowest-free-id linked table: id allocator with an ordered doubly linked list.
//
//  Channel   Direction  Handshake              Word contents
//  req_*     in         req_tvalid/req_tready  tuser: cmd; tdata: id_in, data_in
//  rsp_*     out        rsp_tvalid/rsp_tready  tuser: status; tdata: id_out, data_out
//
// One command is in flight at a time. A live remove and an add fix their neighbors'
// links, one neighbor fix a cycle, through the single write port of the link
// memory.
// Reset clears the used marks and the head links at once; no clearing pass.
// A finished word waits in the output register while the next command is taken;
// a command only stalls in its response step when that register is still full.
`default_nettype none

module lowest_free_id_linked_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata fields from bit 0: id_in[7:0], data_in[31:0]
   input  wire logic [lfit_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser fields from bit 0: cmd[1:0]
   input  wire logic [lfit_pkg::CMD_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata fields from bit 0: id_out[7:0], data_out[31:0]
   output logic [lfit_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser fields from bit 0: status[1:0]
   output logic [lfit_pkg::STS_W-1:0]          rsp_tuser
);
   import lfit_pkg::*;

`include "lowest_free_id_linked_table_defines.svh"

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_FIND     = 7'b0000010,
      ST_ADD_LINK = 7'b0000100,
      ST_REM_LINK = 7'b0001000,
      ST_FIX_NXT  = 7'b0010000,
      ST_FIX_PRV  = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   // Lowest set bit within one group of used marks.
   function automatic logic [BIT_IDX_W-1:0] low_bit(input logic [GRP_W-1:0] v);
      logic [BIT_IDX_W-1:0] r;
      r = '0;
      for (int i = GRP_W - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_IDX_W'(i);
      end
      return r;
   endfunction

   // Lowest group that still holds a free id.
   function automatic logic [GRP_IDX_W-1:0] low_grp(input logic [GRP_N-1:0] v);
      logic [GRP_IDX_W-1:0] r;
      r = '0;
      for (int i = GRP_N - 1; i >= 0; i--) begin
         if (v[i]) r = GRP_IDX_W'(i);
      end
      return r;
   endfunction

   // Control registers and their next values.
   state_type            state_ff, state_in;
   logic [MAX_IDS-1:0]   used_ff, used_in;
   logic [ID_W-1:0]      head_next_ff, head_next_in;
   logic [ID_W-1:0]      head_prev_ff, head_prev_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // Command context and neighbor fix registers.
   cmd_type              cmd_ff, cmd_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic                 live_ff, live_in;
   logic                 any_free_ff, any_free_in;
   logic [GRP_IDX_W-1:0] grp_ff, grp_in;
   logic [ID_W-1:0]      pick_ff, pick_in;
   logic [ID_W-1:0]      nb_ff, nb_in;
   logic [ID_W-1:0]      na_ff, na_in;
   logic [ID_W-1:0]      fix_nxt_ff, fix_nxt_in;
   logic [ID_W-1:0]      fix_prv_ff, fix_prv_in;

   // Output word register.
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Memories and their ports.
   link_type             link_mem [MAX_IDS];
   logic [DATA_W-1:0]    pay_mem [MAX_IDS];
   link_type             link_rd_ff;
   logic [DATA_W-1:0]    pay_rd_ff;
   logic                 link_re;
   logic [ID_W-1:0]      link_ra;
   logic                 link_we_nxt;
   logic                 link_we_prv;
   logic [ID_W-1:0]      link_wa;
   link_type             link_wd;
   logic                 pay_re;
   logic                 pay_we;

   // Input word fields.
   logic                 req_accept;
   cmd_type              req_cmd;
   logic [ID_W-1:0]      req_id;
   logic [DATA_W-1:0]    req_data;

   // Free-id search and add neighbors.
   logic [MAX_IDS-1:0]   free_vec;
   logic [GRP_N-1:0]     grp_free;
   logic [GRP_W-1:0]     find_bits;
   logic [ID_W-1:0]      find_pick;
   logic [ID_W-1:0]      find_before;
   logic [ID_W-1:0]      add_before;
   logic [ID_W-1:0]      add_after;
   logic [ID_W-1:0]      rem_before;
   logic [ID_W-1:0]      rem_after;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tuser);
   assign req_id     = req_tdata[ID_W-1:0];
   assign req_data   = req_tdata[ID_W +: DATA_W];

   // The head is never handed out, so its mark counts as taken.
   always_comb begin
      free_vec    = ~used_ff;
      free_vec[0] = 1'b0;
      for (int g = 0; g < GRP_N; g++) begin
         grp_free[g] = |free_vec[g*GRP_W +: GRP_W];
      end
   end

   // Second search step inside the group chosen at accept.
   assign find_bits   = free_vec[{grp_ff, BIT_IDX_W'(0)} +: GRP_W];
   assign find_pick   = {grp_ff, low_bit(find_bits)};
   assign find_before = find_pick - ID_W'(1);

   // Every id below the new one is live, so it goes right after id-1.
   assign add_before = pick_ff - ID_W'(1);
   assign add_after  = (add_before == '0) ? head_next_ff : link_rd_ff.nxt;
   assign rem_before = link_rd_ff.prv;
   assign rem_after  = link_rd_ff.nxt;

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      head_next_in  = head_next_ff;
      head_prev_in  = head_prev_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      data_in       = data_ff;
      live_in       = live_ff;
      any_free_in   = any_free_ff;
      grp_in        = grp_ff;
      pick_in       = pick_ff;
      nb_in         = nb_ff;
      na_in         = na_ff;
      fix_nxt_in    = fix_nxt_ff;
      fix_prv_in    = fix_prv_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      link_re       = 1'b0;
      link_ra       = req_id;
      link_we_nxt   = 1'b0;
      link_we_prv   = 1'b0;
      link_wa       = '0;
      link_wd       = '0;
      pay_re        = 1'b0;
      pay_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Read both memories at the given id; get and next use it in the response step.
               link_re     = 1'b1;
               pay_re      = 1'b1;
               cmd_in      = req_cmd;
               id_in       = req_id;
               data_in     = req_data;
               live_in     = (req_id != '0) && used_ff[req_id];
               any_free_in = |grp_free;
               grp_in      = low_grp(grp_free);
               case (req_cmd)
                  CMD_ADD:    state_in = (|grp_free) ? ST_FIND : ST_RESP;
                  CMD_REMOVE: begin
                     state_in = ((req_id != '0) && used_ff[req_id]) ? ST_REM_LINK : ST_RESP;
                  end
                  default:    state_in = ST_RESP;
               endcase
            end
         end

         ST_FIND: begin
            // Claim the id, store the payload and fetch the forward link of id-1.
            pick_in            = find_pick;
            used_in[find_pick] = 1'b1;
            pay_we             = 1'b1;
            link_re            = (find_before != '0);
            link_ra            = find_before;
            state_in           = ST_ADD_LINK;
         end

         ST_ADD_LINK: begin
            // Write the new entry's links; head links are registers.
            link_we_nxt = 1'b1;
            link_we_prv = 1'b1;
            link_wa     = pick_ff;
            link_wd.prv = add_before;
            link_wd.nxt = add_after;
            if (add_before == '0) head_next_in = pick_ff;
            if (add_after == '0) head_prev_in = pick_ff;
            nb_in      = add_before;
            na_in      = add_after;
            fix_nxt_in = pick_ff;
            fix_prv_in = pick_ff;
            if (add_before != '0) begin
               state_in = ST_FIX_NXT;
            end else if (add_after != '0) begin
               state_in = ST_FIX_PRV;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_REM_LINK: begin
            // Bridge the neighbors of the removed entry and free its id.
            used_in[id_ff] = 1'b0;
            if (rem_before == '0) head_next_in = rem_after;
            if (rem_after == '0) head_prev_in = rem_before;
            nb_in      = rem_before;
            na_in      = rem_after;
            fix_nxt_in = rem_after;
            fix_prv_in = rem_before;
            if (rem_before != '0) begin
               state_in = ST_FIX_NXT;
            end else if (rem_after != '0) begin
               state_in = ST_FIX_PRV;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_FIX_NXT: begin
            link_we_nxt = 1'b1;
            link_wa     = nb_ff;
            link_wd.nxt = fix_nxt_ff;
            state_in    = (na_ff != '0) ? ST_FIX_PRV : ST_RESP;
         end

         ST_FIX_PRV: begin
            link_we_prv = 1'b1;
            link_wa     = na_ff;
            link_wd.prv = fix_prv_ff;
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            // Load the output word once the previous one has been taken.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_id_in     = '0;
               rsp_data_in   = '0;
               rsp_status_in = STS_OK;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (any_free_ff) begin
                        rsp_id_in = pick_ff;
                     end else begin
                        rsp_status_in = STS_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!live_ff) rsp_status_in = STS_UNUSED;
                  end
                  CMD_GET: begin
                     if (live_ff) begin
                        rsp_data_in = pay_rd_ff;
                     end else begin
                        rsp_status_in = STS_UNUSED;
                     end
                  end
                  CMD_NEXT: begin
                     if (id_ff == '0) begin
                        rsp_id_in = head_next_ff;
                     end else if (live_ff) begin
                        rsp_id_in = link_rd_ff.nxt;
                     end else begin
                        rsp_status_in = STS_UNUSED;
                     end
                  end
                  default: rsp_status_in = STS_UNUSED;
               endcase
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         head_next_ff  <= '0;
         head_prev_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         head_next_ff  <= head_next_in;
         head_prev_ff  <= head_prev_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Context and output word registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      data_ff       <= data_in;
      live_ff       <= live_in;
      any_free_ff   <= any_free_in;
      grp_ff        <= grp_in;
      pick_ff       <= pick_in;
      nb_ff         <= nb_in;
      na_ff         <= na_in;
      fix_nxt_ff    <= fix_nxt_in;
      fix_prv_ff    <= fix_prv_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Link memory: one write port with per-half enables, one registered read.
   always_ff @(posedge clock) begin
      if (link_we_nxt) link_mem[link_wa].nxt <= link_wd.nxt;
      if (link_we_prv) link_mem[link_wa].prv <= link_wd.prv;
      if (link_re) link_rd_ff <= link_mem[link_ra];
   end

   // Payload memory: written by add, read at accept.
   always_ff @(posedge clock) begin
      if (pay_we) pay_mem[pick_in] <= data_ff;
      if (pay_re) pay_rd_ff <= pay_mem[req_id];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_data_ff, rsp_id_ff});
   assign rsp_tuser  = rsp_status_ff;

   // The search must land on a free id other than the head.
   `LFIT_ASSERT_NOW(a_pick_free, state_ff == ST_FIND,
      !used_ff[find_pick] && (find_pick != '0), "add picked an id that is in use")
   // The head links live in registers, never in the link memory.
   `LFIT_ASSERT_NOW(a_no_head_write, link_we_nxt || link_we_prv,
      link_wa != '0, "link memory write to the head slot")
   // Reads and writes of the link memory never share a cycle.
   `LFIT_ASSERT_NOW(a_rw_apart, link_re,
      !(link_we_nxt || link_we_prv), "link memory read during a write")
   // A removed id is free from the cycle after its links are bridged.
   `LFIT_ASSERT_NEXT(a_remove_frees, state_ff == ST_REM_LINK,
      !used_ff[id_ff], "removed id still marked used")
   // A full output register holds the sequencer in its response step.
   `LFIT_ASSERT_NEXT(a_resp_hold, (state_ff == ST_RESP) && rsp_tvalid_ff && !rsp_tready,
      state_ff == ST_RESP, "response step left while output was full")

endmodule

`default_nettype wire
